// File: hdl/inline_color_tag_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Inline color tag parser - assertion macros
// Concurrent assertion shorthands used by the top level, which checks itself.
// ----------------------------------------------------------------------------
`ifndef INLINE_COLOR_TAG_PARSER_CORE_MACROS_SVH
`define INLINE_COLOR_TAG_PARSER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ICTP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ictp: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define ICTP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ictp: next-cycle check failed");

`endif

// File: hdl/ictp_pkg.sv
// ----------------------------------------------------------------------------
// Inline color tag parser - package
// Item types, character codes and the character classifier.
// ----------------------------------------------------------------------------
package ictp_pkg;

	localparam int WINDOW_DEPTH = 10;
	localparam int WIN_CNT_W    = $clog2(WINDOW_DEPTH + 1);
	localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int SHORT_DIGITS = 6;
	localparam int LONG_DIGITS  = 8;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [15:0] OPEN_BRACE  = 16'h007B;
	localparam logic [15:0] CLOSE_BRACE = 16'h007D;
	localparam logic [15:0] CHAR_DIG_LO = 16'h0030;
	localparam logic [15:0] CHAR_DIG_HI = 16'h0039;
	localparam logic [15:0] CHAR_LC_LO  = 16'h0061;
	localparam logic [15:0] CHAR_LC_HI  = 16'h0066;
	localparam logic [15:0] CHAR_UC_LO  = 16'h0041;
	localparam logic [15:0] CHAR_UC_HI  = 16'h0046;
	localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;

	typedef enum logic {
		KIND_CHAR = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] character;
		logic [31:0] default_color;
	} in_item_t;

	typedef struct packed {
		logic [15:0] out_char;
		logic [31:0] out_color;
		logic        has_char;
		logic        run_last;
		logic        message_end;
	} out_item_t;

	// Character with its tag class worked out up front.
	typedef struct packed {
		logic [15:0] character;
		logic        is_open;
		logic        is_close;
		logic        is_hex;
		logic [3:0]  nibble;
	} cls_char_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] default_color;
		cls_char_t   glyph;
	} q_item_t;

	typedef struct packed {
		logic                 idle;
		logic [WIN_CNT_W-1:0] win_cnt;
	} stat_t;

	function automatic cls_char_t classify(input logic [15:0] c);
		cls_char_t r;
		r.character = c;
		r.is_open   = (c == OPEN_BRACE);
		r.is_close  = (c == CLOSE_BRACE);
		r.is_hex    = 1'b1;
		r.nibble    = c[3:0];
		if (c inside {[CHAR_DIG_LO:CHAR_DIG_HI]}) begin
			r.nibble = c[3:0];
		end else if (c inside {[CHAR_LC_LO:CHAR_LC_HI], [CHAR_UC_LO:CHAR_UC_HI]}) begin
			r.nibble = 4'(c[3:0] + 4'd9);
		end else begin
			r.is_hex = 1'b0;
			r.nibble = '0;
		end
		return r;
	endfunction

endpackage

// File: hdl/ictp_chan_if.sv
// ----------------------------------------------------------------------------
// Inline color tag parser - channel interface
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface ictp_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/inline_color_tag_parser_core.sv
// ----------------------------------------------------------------------------
// Inline color tag parser - top level
// Strips {RRGGBB} and {AARRGGBB} color tags from a character stream and
// tags every visible character with the ARGB color in force.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                        | Handshake
//  --------+-----+------------------------------------------------+-----------
//  text    | in  | kind, character, default_color                 | valid/ready
//  glyph   | out | out_char, out_color, has_char, run_last,        | valid/ready
//          |     | message_end                                    |
//
//  Steps: the back end takes a request while idle, then spends a drain step on
//  each released character and each matched tag and a closing step before it
//  returns to idle; the front end queues a request every cycle while not full.
//  Reset: arst_n empties queue, window and result register; a new message starts.
//  Stalls: a full result register holds the drain, a full queue drops ready on
//  text; each character is held until the next step shows whether it was last.
//
`include "inline_color_tag_parser_core_macros.svh"

module inline_color_tag_parser_core #(
	parameter int QUEUE_DEPTH = ictp_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	ictp_chan_if.sink   text,
	ictp_chan_if.source glyph
);

	// Classified jobs from the front end to the back end.
	ictp_chan_if #(.payload_t(ictp_pkg::q_item_t)) q_chan ();

	ictp_pkg::stat_t stat;

	// Front: accept, classify, queue.
	ictp_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.job    (q_chan)
	);

	// Back: append to window, resolve tags, release characters.
	ictp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (q_chan),
		.glyph  (glyph),
		.stat   (stat)
	);

	// A bare result closes the message and carries no character.
	`ICTP_ASSERT_IMPL(a_bare_closes, clk, arst_n, glyph.valid && !glyph.payload.has_char, glyph.payload.run_last && glyph.payload.message_end && glyph.payload.out_char == '0)

	// The end of a message is always the last result of its request.
	`ICTP_ASSERT_IMPL(a_end_is_last, clk, arst_n, glyph.valid && glyph.payload.message_end, glyph.payload.run_last)

	// Between requests the window never stays full.
	`ICTP_ASSERT_IMPL(a_window_open, clk, arst_n, stat.idle, stat.win_cnt < ictp_pkg::WIN_CNT_W'(ictp_pkg::WINDOW_DEPTH))

	// The back end leaves idle only on a queued job.
	`ICTP_ASSERT_NEXT(a_idle_holds, clk, arst_n, stat.idle && !q_chan.valid, stat.idle)

endmodule

// File: hdl/ictp_front.sv
// ----------------------------------------------------------------------------
// Inline color tag parser - front end
// Accepts requests, classifies the character and queues the job.
// ----------------------------------------------------------------------------
module ictp_front #(
	parameter int QUEUE_DEPTH = ictp_pkg::QUEUE_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	ictp_chan_if.sink   text,
	ictp_chan_if.source job
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ictp_pkg::q_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	ictp_pkg::q_item_t item;
	logic              push;
	logic              pop;

	assign text.ready  = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign job.valid   = (cnt_q != '0);
	assign job.payload = mem_q[rd_ptr_q];
	assign push        = text.valid && text.ready;
	assign pop         = job.valid && job.ready;

	always_comb begin
		item.kind          = text.payload.kind;
		item.default_color = text.payload.default_color;
		item.glyph         = ictp_pkg::classify(text.payload.character);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

endmodule

// File: hdl/ictp_back.sv
// ----------------------------------------------------------------------------
// Inline color tag parser - back end
// Pending window, tag judge, color state and result register.
// ----------------------------------------------------------------------------
module ictp_back (
	input  logic            clk,
	input  logic            arst_n,
	ictp_chan_if.sink        job,
	ictp_chan_if.source      glyph,
	output ictp_pkg::stat_t  stat
);
	localparam int D     = ictp_pkg::WINDOW_DEPTH;
	localparam int CW    = ictp_pkg::WIN_CNT_W;
	localparam int IW    = ictp_pkg::WIN_IDX_W;
	localparam int SD    = ictp_pkg::SHORT_DIGITS;
	localparam int LD    = ictp_pkg::LONG_DIGITS;
	localparam int SHORT_W = 4 * SD;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	typedef enum logic [1:0] {
		ACT_EMIT,
		ACT_TAG6,
		ACT_TAG8,
		ACT_DONE
	} act_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	ictp_pkg::cls_char_t   win_q [D];
	logic [31:0]           color_q;
	logic                  at_start_q;
	logic                  final_q;
	logic                  hold_valid_q;
	logic [15:0]           hold_char_q;
	logic [31:0]           hold_color_q;
	logic                  out_valid_q;
	ictp_pkg::out_item_t   out_data_q;

	logic                  fail6;
	logic                  fail8;
	logic [SHORT_W-1:0]    v6;
	logic [31:0]           v8;
	act_t                  act;
	logic                  need_push;
	ictp_pkg::out_item_t   push_data;
	logic                  out_free;
	logic                  step_go;
	logic                  push;
	logic                  pop;
	logic                  append;
	logic [IW-1:0]         wr_idx;
	logic [CW-1:0]         app_cnt;

	// Judge the tag that opens at the oldest entry.
	always_comb begin
		fail6 = 1'b0;
		fail8 = 1'b0;
		v6    = '0;
		v8    = '0;
		for (int i = 1; i <= SD; i++) begin
			if (CW'(i) < cnt_q && !win_q[i].is_hex) fail6 = 1'b1;
			v6 = {v6[SHORT_W-5:0], win_q[i].nibble};
		end
		if (CW'(SD + 1) < cnt_q && !win_q[SD + 1].is_close) fail6 = 1'b1;
		for (int i = 1; i <= LD; i++) begin
			if (CW'(i) < cnt_q && !win_q[i].is_hex) fail8 = 1'b1;
			v8 = {v8[27:0], win_q[i].nibble};
		end
		if (CW'(LD + 1) < cnt_q && !win_q[LD + 1].is_close) fail8 = 1'b1;

		if (cnt_q == '0) begin
			act = ACT_DONE;
		end else if (!win_q[0].is_open) begin
			act = ACT_EMIT;
		end else if (!fail6 && cnt_q > CW'(SD + 1)) begin
			act = ACT_TAG6;
		end else if (!fail6 && !final_q) begin
			act = ACT_DONE;
		end else if (!fail8 && cnt_q > CW'(LD + 1)) begin
			act = ACT_TAG8;
		end else if (!fail8 && !final_q) begin
			act = ACT_DONE;
		end else begin
			act = ACT_EMIT;
		end
	end

	// The held character goes out once the next step shows whether it was last.
	always_comb begin
		need_push = 1'b0;
		push_data = '0;
		case (act)
			ACT_EMIT: begin
				need_push             = hold_valid_q;
				push_data.out_char    = hold_char_q;
				push_data.out_color   = hold_color_q;
				push_data.has_char    = 1'b1;
			end
			ACT_DONE: begin
				need_push             = hold_valid_q || final_q;
				push_data.run_last    = 1'b1;
				if (hold_valid_q) begin
					push_data.out_char    = hold_char_q;
					push_data.out_color   = hold_color_q;
					push_data.has_char    = 1'b1;
					push_data.message_end = final_q;
				end else begin
					push_data.out_color   = color_q;
					push_data.message_end = 1'b1;
				end
			end
			default: begin
				need_push = 1'b0;
			end
		endcase
	end

	assign out_free      = !out_valid_q || glyph.ready;
	assign step_go       = (state_q == ST_DRAIN) && (!need_push || out_free);
	assign push          = step_go && need_push;
	assign job.ready     = (state_q == ST_IDLE);
	assign pop           = job.valid && job.ready;
	assign append        = pop && (job.payload.kind == ictp_pkg::KIND_CHAR);
	assign wr_idx        = (cnt_q == CW'(D)) ? IW'(D - 1) : cnt_q[IW-1:0];
	assign app_cnt       = CW'(wr_idx) + 1'b1;
	assign glyph.valid   = out_valid_q;
	assign glyph.payload = out_data_q;
	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.win_cnt  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			color_q      <= '0;
			at_start_q   <= 1'b1;
			final_q      <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (glyph.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (at_start_q) begin
							color_q    <= job.payload.default_color;
							at_start_q <= 1'b0;
						end
						final_q <= (job.payload.kind == ictp_pkg::KIND_END);
						if (append) cnt_q <= app_cnt;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (step_go) begin
						case (act)
							ACT_EMIT: begin
								hold_valid_q <= 1'b1;
								cnt_q        <= cnt_q - 1'b1;
							end
							ACT_TAG6: begin
								color_q <= ictp_pkg::OPAQUE_ALPHA | 32'(v6);
								cnt_q   <= cnt_q - CW'(SD + 2);
							end
							ACT_TAG8: begin
								color_q <= v8;
								cnt_q   <= '0;
							end
							default: begin
								hold_valid_q <= 1'b0;
								if (final_q) begin
									cnt_q      <= '0;
									at_start_q <= 1'b1;
								end
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= push_data;
		end
		if (step_go && act == ACT_EMIT) begin
			hold_char_q  <= win_q[0].character;
			hold_color_q <= color_q;
		end
		if (append) begin
			for (int i = 0; i < D; i++) begin
				if (IW'(i) == wr_idx) win_q[i] <= job.payload.glyph;
			end
		end else if (step_go && act == ACT_EMIT) begin
			for (int i = 0; i < D - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
		end else if (step_go && act == ACT_TAG6) begin
			for (int i = 0; i < D - (SD + 2); i++) begin
				win_q[i] <= win_q[i + SD + 2];
			end
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inline color tag parser - testbench
// Drives messages of characters, color tags and end markers into the parser
// and checks every released glyph, field by field, against a shadow parser in
// the bench or a typed row's fixed glyph. A short table of hand-picked requests
// comes first, then random messages under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum int {
		VERDICT_FAIL,
		VERDICT_MATCH,
		VERDICT_WAIT
	} tag_verdict_t;

	// One row of the directed table; typed rows carry their single glyph.
	typedef struct {
		ictp_pkg::in_item_t  req;
		bit                  typed;
		ictp_pkg::out_item_t want;
	} stim_row_t;

	// Characters just outside the hex ranges, plus two that alias 'a' and '{' in
	// their low byte, to probe the classifier.
	localparam logic [15:0] NEAR_MISS [8] = '{
		16'h002F, 16'h003A, 16'h0040, 16'h0047,
		16'h0060, 16'h0067, 16'h0161, 16'h7B7B
	};

	logic clk;
	logic arst_n;

	ictp_chan_if #(.payload_t(ictp_pkg::in_item_t))  text_ch  ();
	ictp_chan_if #(.payload_t(ictp_pkg::out_item_t)) glyph_ch ();

	inline_color_tag_parser_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.glyph  (glyph_ch)
	);

	// Shadow parser state.
	logic [15:0] shadow_win [ictp_pkg::WINDOW_DEPTH];
	int          shadow_cnt;
	logic [31:0] shadow_color;
	bit          shadow_fresh;

	ictp_pkg::out_item_t step_glyphs [$];   // glyphs released by the request in hand
	ictp_pkg::out_item_t glyph_backlog [$]; // glyphs still owed by the block
	ictp_pkg::in_item_t  text_plan [$];     // requests of the message being built
	stim_row_t           directed [$];

	int fail_count;
	int sender_idle_pct;
	int recv_stall_pct;
	int hold_left;

	// ------------------------------------------------------------------
	// Shadow parser
	// ------------------------------------------------------------------

	function automatic bit hex_nibble(input logic [15:0] c, output logic [3:0] nib);
		nib = '0;
		if (c >= ictp_pkg::CHAR_DIG_LO && c <= ictp_pkg::CHAR_DIG_HI) begin
			nib = 4'(c - ictp_pkg::CHAR_DIG_LO);
			return 1'b1;
		end
		if (c >= ictp_pkg::CHAR_LC_LO && c <= ictp_pkg::CHAR_LC_HI) begin
			nib = 4'(c - ictp_pkg::CHAR_LC_LO + 10);
			return 1'b1;
		end
		if (c >= ictp_pkg::CHAR_UC_LO && c <= ictp_pkg::CHAR_UC_HI) begin
			nib = 4'(c - ictp_pkg::CHAR_UC_LO + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Judge a tag of the given digit count opening at window entry 0.
	function automatic tag_verdict_t judge_tag(input int digits, input bit flush,
			output logic [31:0] value);
		logic [3:0] nib;
		value = '0;
		for (int i = 1; i <= digits + 1; i++) begin
			if (i >= shadow_cnt) continue;
			if (i == digits + 1) begin
				if (shadow_win[i] != ictp_pkg::CLOSE_BRACE) return VERDICT_FAIL;
			end else begin
				if (!hex_nibble(shadow_win[i], nib)) return VERDICT_FAIL;
				value = {value[27:0], nib};
			end
		end
		if (digits + 1 < shadow_cnt) return VERDICT_MATCH;
		return flush ? VERDICT_FAIL : VERDICT_WAIT;
	endfunction

	function automatic void drop_front(input int n);
		if (n >= shadow_cnt) begin
			shadow_cnt = 0;
			return;
		end
		for (int i = 0; i < shadow_cnt - n; i++)
			shadow_win[i] = shadow_win[i + n];
		shadow_cnt -= n;
	endfunction

	function automatic void emit_front();
		ictp_pkg::out_item_t g;
		g = '{out_char: shadow_win[0], out_color: shadow_color, has_char: 1'b1,
			run_last: 1'b0, message_end: 1'b0};
		step_glyphs = {step_glyphs, g};
		drop_front(1);
	endfunction

	// Release everything that can be decided now.
	function automatic void release_window(input bit flush);
		logic [31:0]  value;
		tag_verdict_t v;
		while (shadow_cnt > 0 && step_glyphs.size() < ictp_pkg::WINDOW_DEPTH) begin
			if (shadow_win[0] != ictp_pkg::OPEN_BRACE) begin
				emit_front();
				continue;
			end
			v = judge_tag(ictp_pkg::SHORT_DIGITS, flush, value);
			if (v == VERDICT_WAIT) break;
			if (v == VERDICT_MATCH) begin
				shadow_color = ictp_pkg::OPAQUE_ALPHA | value;
				drop_front(ictp_pkg::SHORT_DIGITS + 2);
				continue;
			end
			v = judge_tag(ictp_pkg::LONG_DIGITS, flush, value);
			if (v == VERDICT_WAIT) break;
			if (v == VERDICT_MATCH) begin
				shadow_color = value;
				drop_front(ictp_pkg::LONG_DIGITS + 2);
				continue;
			end
			emit_front();
		end
	endfunction

	// Advance the shadow parser by one request; the released glyphs land in
	// step_glyphs with their run and message flags set.
	function automatic void predict_glyphs(input ictp_pkg::in_item_t req);
		ictp_pkg::out_item_t g;
		step_glyphs.delete();
		if (shadow_fresh) begin
			shadow_color = req.default_color;
			shadow_fresh = 1'b0;
		end
		if (req.kind == ictp_pkg::KIND_CHAR) begin
			if (shadow_cnt >= ictp_pkg::WINDOW_DEPTH) shadow_cnt = ictp_pkg::WINDOW_DEPTH - 1;
			shadow_win[shadow_cnt] = req.character;
			shadow_cnt++;
			release_window(1'b0);
			if (step_glyphs.size() > 0) begin
				g = step_glyphs.pop_back();
				g.run_last = 1'b1;
				step_glyphs = {step_glyphs, g};
			end
		end else begin
			release_window(1'b1);
			shadow_cnt = 0;
			if (step_glyphs.size() == 0) begin
				g = '{out_char: 16'h0000, out_color: shadow_color, has_char: 1'b0,
					run_last: 1'b0, message_end: 1'b0};
				step_glyphs = {step_glyphs, g};
			end
			g = step_glyphs.pop_back();
			g.run_last    = 1'b1;
			g.message_end = 1'b1;
			step_glyphs = {step_glyphs, g};
			shadow_fresh = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [15:0] hex_glyph(input logic [3:0] v, input bit upper);
		if (v < 10) return ictp_pkg::CHAR_DIG_LO + 16'(v);
		if (upper) return ictp_pkg::CHAR_UC_LO + 16'(v) - 16'd10;
		return ictp_pkg::CHAR_LC_LO + 16'(v) - 16'd10;
	endfunction

	function automatic logic [15:0] random_hex();
		return hex_glyph(4'($urandom_range(15)), 1'($urandom_range(1)));
	endfunction

	function automatic logic [31:0] pick_default();
		case ($urandom_range(9))
			0: begin
				return 32'h0000_0000;
			end
			1: begin
				return 32'hFFFF_FFFF;
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	function automatic ictp_pkg::in_item_t char_req(input logic [15:0] c,
			input logic [31:0] d);
		ictp_pkg::in_item_t r;
		r = '{kind: ictp_pkg::KIND_CHAR, character: c, default_color: d};
		return r;
	endfunction

	function automatic void plan_char(input logic [15:0] c);
		text_plan = {text_plan, char_req(c, pick_default())};
	endfunction

	function automatic void plain_row(input ictp_pkg::kind_t k, input logic [15:0] c,
			input logic [31:0] d);
		stim_row_t r;
		r.req   = '{kind: k, character: c, default_color: d};
		r.typed = 1'b0;
		r.want  = '0;
		directed = {directed, r};
	endfunction

	function automatic void typed_row(input ictp_pkg::kind_t k, input logic [15:0] c,
			input logic [31:0] d, input ictp_pkg::out_item_t want);
		stim_row_t r;
		r.req   = '{kind: k, character: c, default_color: d};
		r.typed = 1'b1;
		r.want  = want;
		directed = {directed, r};
	endfunction

	// Build one random message: mostly well-formed tags and text, with some
	// broken tags and stray braces; now and then the end marker is left off
	// so the next message runs on from this one.
	function automatic void plan_message();
		int                 k;
		int                 pick;
		ictp_pkg::in_item_t r;
		repeat ($urandom_range(1, 5)) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				case ($urandom_range(3))
					0: begin
						plan_char(16'($urandom()));
					end
					1: begin
						plan_char(random_hex());
					end
					2: begin
						plan_char(NEAR_MISS[$urandom_range(7)]);
					end
					default: begin
						plan_char(ictp_pkg::CLOSE_BRACE);
					end
				endcase
			end else if (pick < 70) begin
				plan_char(ictp_pkg::OPEN_BRACE);
				repeat ((pick < 50) ? ictp_pkg::SHORT_DIGITS : ictp_pkg::LONG_DIGITS)
					plan_char(random_hex());
				plan_char(ictp_pkg::CLOSE_BRACE);
			end else if (pick < 90) begin
				plan_char(ictp_pkg::OPEN_BRACE);
				k = $urandom_range(0, ictp_pkg::LONG_DIGITS);
				repeat (k) plan_char(random_hex());
				case ($urandom_range(2))
					0: begin
						plan_char(NEAR_MISS[$urandom_range(7)]);
					end
					1: begin
						plan_char(ictp_pkg::CLOSE_BRACE);
					end
					default: begin
					end
				endcase
			end else begin
				plan_char(ictp_pkg::OPEN_BRACE);
				plan_char(($urandom_range(1) != 0) ? ictp_pkg::OPEN_BRACE : 16'($urandom()));
			end
		end
		if ($urandom_range(7) != 0) begin
			r = '{kind: ictp_pkg::KIND_END, character: 16'($urandom()),
				default_color: $urandom()};
			text_plan = {text_plan, r};
		end
	endfunction

	// ------------------------------------------------------------------
	// Text driver
	// ------------------------------------------------------------------

	// Offer one request after a random idle gap, hold it until the block
	// takes it, then book what it releases.
	task automatic send_request(input ictp_pkg::in_item_t req, input bit typed,
			input ictp_pkg::out_item_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct && gap < 200) gap++;
		if (gap > 0) begin
			@(negedge clk);
			text_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		text_ch.valid   <= 1'b1;
		text_ch.payload <= req;
		do @(posedge clk); while (!text_ch.ready);
		predict_glyphs(req);
		if (typed) begin
			glyph_backlog = {glyph_backlog, want};
		end else begin
			glyph_backlog = {glyph_backlog, step_glyphs};
		end
	endtask

	// Drop valid and hold the sender until every owed glyph has come.
	task automatic settle();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (glyph_backlog.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input int target);
		int sent;
		sender_idle_pct = s_pct;
		recv_stall_pct  = r_pct;
		sent = 0;
		while (sent < target) begin
			text_plan.delete();
			plan_message();
			foreach (text_plan[i]) send_request(text_plan[i], 1'b0, '0);
			sent += text_plan.size();
		end
		settle();
	endtask

	// ------------------------------------------------------------------
	// Glyph checker
	// ------------------------------------------------------------------

	task automatic check_glyph(input ictp_pkg::out_item_t got);
		ictp_pkg::out_item_t want;
		if (glyph_backlog.size() == 0) begin
			$error("unexpected glyph: out_char=%h out_color=%h has_char=%b run_last=%b message_end=%b",
				got.out_char, got.out_color, got.has_char, got.run_last, got.message_end);
			fail_count++;
			return;
		end
		want = glyph_backlog.pop_front();
		if (got.out_char !== want.out_char) begin
			$error("out_char: expected %h, got %h", want.out_char, got.out_char);
			fail_count++;
		end
		if (got.out_color !== want.out_color) begin
			$error("out_color: expected %h, got %h", want.out_color, got.out_color);
			fail_count++;
		end
		if (got.has_char !== want.has_char) begin
			$error("has_char: expected %b, got %b", want.has_char, got.has_char);
			fail_count++;
		end
		if (got.run_last !== want.run_last) begin
			$error("run_last: expected %b, got %b", want.run_last, got.run_last);
			fail_count++;
		end
		if (got.message_end !== want.message_end) begin
			$error("message_end: expected %b, got %b", want.message_end, got.message_end);
			fail_count++;
		end
	endtask

	// Sample the glyph channel at the rising edge.
	always @(posedge clk) begin
		if (arst_n && glyph_ch.valid === 1'b1 && glyph_ch.ready === 1'b1)
			check_glyph(glyph_ch.payload);
	end

	// ------------------------------------------------------------------
	// Clock, receiver and time limit
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: stall at random, or hold off outright while hold_left runs.
	initial begin
		glyph_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				glyph_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				glyph_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		text_ch.valid   = 1'b0;
		text_ch.payload = '0;
		arst_n          = 1'b0;
		fail_count      = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left       = 0;
		shadow_cnt      = 0;
		shadow_color    = '0;
		shadow_fresh    = 1'b1;
		foreach (shadow_win[i]) shadow_win[i] = '0;

		// Directed table. Typed rows: an empty flush right after reset, and
		// the extreme characters of a fresh message.
		typed_row(ictp_pkg::KIND_END, 16'h0000, 32'hFFFF_FFFF,
			'{out_char: 16'h0000, out_color: 32'hFFFF_FFFF, has_char: 1'b0,
			run_last: 1'b1, message_end: 1'b1});
		typed_row(ictp_pkg::KIND_CHAR, 16'hFFFF, 32'h0000_0000,
			'{out_char: 16'hFFFF, out_color: 32'h0000_0000, has_char: 1'b1,
			run_last: 1'b1, message_end: 1'b0});
		// default color is ignored past the first request of a message
		typed_row(ictp_pkg::KIND_CHAR, 16'h0000, 32'hFFFF_FFFF,
			'{out_char: 16'h0000, out_color: 32'h0000_0000, has_char: 1'b1,
			run_last: 1'b1, message_end: 1'b0});
		// six-digit tag, mixed case: window waits, then swallows the tag
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::OPEN_BRACE, 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hA, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hB, 1'b1), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h0, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h9, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hF, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hF, 1'b1), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::CLOSE_BRACE, 32'h0);
		// brace followed by a brace: first fails as text, second opens an
		// eight-digit tag once the six-digit form is ruled out
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::OPEN_BRACE, 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::OPEN_BRACE, 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h8, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h0, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h1, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hC, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hD, 1'b1), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'hE, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h5, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h6, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::CLOSE_BRACE, 32'h0);
		// incomplete tag at the end marker: flush releases it as text
		plain_row(ictp_pkg::KIND_CHAR, ictp_pkg::OPEN_BRACE, 32'h0);
		plain_row(ictp_pkg::KIND_CHAR, hex_glyph(4'h7, 1'b0), 32'h0);
		plain_row(ictp_pkg::KIND_END, 16'hFFFF, 32'h0);

		// Hold reset, then release it at a falling edge.
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		recv_stall_pct = 30;
		foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].want);
		settle();

		// Random messages under each idle pattern.
		run_phase(0, 0, 35);
		run_phase(80, 0, 30);
		run_phase(0, 80, 30);
		run_phase(23, 23, 30);

		// Back pressure: hold the receiver off while plain text streams in,
		// so the block fills up and drops ready on text.
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		hold_left       = 150;
		repeat (28) send_request(char_req(16'($urandom()) | 16'h8000, $urandom()), 1'b0, '0);
		send_request('{kind: ictp_pkg::KIND_END, character: 16'h0000, default_color: 32'h0},
			1'b0, '0);
		settle();

		// Let any stray glyph show up before the verdict.
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
